// File: rtl/core/plll_pkg.sv
// shared types and constants of the positional linked list manager
`default_nettype none
package plll_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int ACT_W       = 3;
  localparam int POS_W       = 5;
  localparam int IO_WORD_W   = 32;
  localparam int IO_COUNT_W  = 5;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_PREPEND   = 3'd1,
    ACT_INSERT    = 3'd2,
    ACT_REM_FIRST = 3'd3,
    ACT_REM_LAST  = 3'd4,
    ACT_REM_AT    = 3'd5,
    ACT_READ      = 3'd6,
    ACT_CLEAR     = 3'd7
  } action_t;

  typedef struct packed {
    logic success;
    logic is_empty;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/plll_ram.sv
// single-port-write, single-port-read synchronous ram with registered read
`default_nettype none
module plll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/plll_seq.sv
// list sequencer: decodes a request, walks the links and updates the node stores
`default_nettype none
module plll_seq #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  plll_pkg::action_t          in_action,
  input  logic [plll_pkg::POS_W-1:0] in_position,
  input  logic [WORD_BITS-1:0]       in_word,
  input  logic                       out_free,
  output logic                       res_valid,
  output plll_pkg::status_t          res_status,
  output logic [WORD_BITS-1:0]       res_word,
  output logic [CNT_W-1:0]           res_count,
  output logic [IDX_W-1:0]           link_raddr,
  input  logic [IDX_W-1:0]           link_rdata,
  output logic                       link_we,
  output logic [IDX_W-1:0]           link_waddr,
  output logic [IDX_W-1:0]           link_wdata,
  output logic [IDX_W-1:0]           val_raddr,
  input  logic [WORD_BITS-1:0]       val_rdata,
  output logic                       val_we,
  output logic [IDX_W-1:0]           val_waddr,
  output logic [WORD_BITS-1:0]       val_wdata
);
  import plll_pkg::*;

  localparam int XW = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SETUP  = 11'b00000000010,
    ST_WALK   = 11'b00000000100,
    ST_LINK   = 11'b00000001000,
    ST_INSFIX = 11'b00000010000,
    ST_NODE   = 11'b00000100000,
    ST_FIX    = 11'b00001000000,
    ST_FREE   = 11'b00010000000,
    ST_VALUE  = 11'b00100000000,
    ST_VGET   = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_t;

  state_t               state, state_next;
  action_t              act;
  logic [POS_W-1:0]     pos;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] result;
  logic                 ok;
  logic [IDX_W-1:0]     head, tail, ftop;
  logic [CNT_W-1:0]     cnt, fresh, fnum;
  logic [IDX_W-1:0]     steps, cur, nd;
  logic                 pend, from_link, has_pred;

  logic [XW-1:0]        posx, cntx, ins_pos, rem_pos;
  logic                 full;
  logic [IDX_W-1:0]     alloc_node, node_now, nd_now;

  assign posx       = XW'(pos);
  assign cntx       = XW'(cnt);
  assign full       = (fnum == '0) && (fresh == CNT_W'(CAPACITY));
  assign alloc_node = (fnum != '0) ? ftop : fresh[IDX_W-1:0];
  // during a walk the next node comes straight from the link read port
  assign node_now   = pend ? link_rdata : cur;
  assign nd_now     = from_link ? link_rdata : nd;

  always_comb begin
    unique case (act)
      ACT_APPEND:  ins_pos = cntx;
      ACT_PREPEND: ins_pos = '0;
      default:     ins_pos = posx;
    endcase
    unique case (act)
      ACT_REM_FIRST: rem_pos = '0;
      ACT_REM_LAST:  rem_pos = cntx - XW'(1);
      default:       rem_pos = posx;
    endcase
  end

  assign in_ready   = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE) && out_free;
  assign res_status = '{success: ok, is_empty: (cnt == '0)};
  assign res_word   = result;
  assign res_count  = cnt;

  // memory port control
  always_comb begin
    link_raddr = ftop;
    link_we    = 1'b0;
    link_waddr = ftop;
    link_wdata = ftop;
    val_raddr  = cur;
    val_we     = 1'b0;
    val_waddr  = alloc_node;
    val_wdata  = word;
    unique case (state)
      ST_SETUP: begin
        if ((act == ACT_APPEND || act == ACT_PREPEND || act == ACT_INSERT) &&
            !full && ins_pos <= cntx) begin
          val_we = 1'b1;
          if (cnt != '0 && ins_pos == '0) begin
            link_we    = 1'b1;
            link_waddr = alloc_node;
            link_wdata = head;
          end else if (cnt != '0 && ins_pos == cntx) begin
            link_we    = 1'b1;
            link_waddr = tail;
            link_wdata = alloc_node;
          end
        end
      end
      ST_WALK: begin
        link_raddr = node_now;
      end
      ST_LINK: begin
        link_raddr = cur;
        if (act == ACT_INSERT) begin
          link_we    = 1'b1;
          link_waddr = cur;
          link_wdata = nd;
        end
      end
      ST_INSFIX: begin
        link_we    = 1'b1;
        link_waddr = nd;
        link_wdata = link_rdata;
      end
      ST_NODE: begin
        link_raddr = nd_now;
        val_raddr  = nd_now;
      end
      ST_FIX: begin
        if (has_pred) begin
          link_we    = 1'b1;
          link_waddr = cur;
          link_wdata = link_rdata;
        end
      end
      ST_FREE: begin
        link_we    = 1'b1;
        link_waddr = nd;
        link_wdata = ftop;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SETUP;
      ST_SETUP: begin
        state_next = ST_DONE;
        unique case (act)
          ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
            if (!full && ins_pos <= cntx && cnt != '0 && ins_pos != '0 && ins_pos != cntx)
              state_next = ST_WALK;
          end
          ACT_REM_FIRST, ACT_REM_LAST, ACT_REM_AT: begin
            if (rem_pos < cntx) state_next = (rem_pos == '0) ? ST_NODE : ST_WALK;
          end
          ACT_READ: begin
            if (posx < cntx) state_next = ST_WALK;
          end
          ACT_CLEAR: state_next = ST_DONE;
        endcase
      end
      ST_WALK: begin
        if (steps == '0) state_next = (act == ACT_READ) ? ST_VALUE : ST_LINK;
      end
      ST_LINK:   state_next = (act == ACT_INSERT) ? ST_INSFIX : ST_NODE;
      ST_INSFIX: state_next = ST_DONE;
      ST_NODE:   state_next = ST_FIX;
      ST_FIX:    state_next = ST_FREE;
      ST_FREE:   state_next = ST_DONE;
      ST_VALUE:  state_next = ST_VGET;
      ST_VGET:   state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      cnt   <= '0;
      fresh <= '0;
      ftop  <= '0;
      fnum  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act  <= in_action;
            pos  <= in_position;
            word <= in_word;
          end
        end
        ST_SETUP: begin
          result <= '0;
          ok     <= 1'b0;
          pend   <= 1'b0;
          cur    <= head;
          unique case (act)
            ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
              if (!full && ins_pos <= cntx) begin
                ok  <= 1'b1;
                cnt <= cnt + CNT_W'(1);
                nd  <= alloc_node;
                // pop the free stack first, fresh nodes once it runs dry
                if (fnum != '0) begin
                  ftop <= link_rdata;
                  fnum <= fnum - CNT_W'(1);
                end else begin
                  fresh <= fresh + CNT_W'(1);
                end
                if (cnt == '0) begin
                  head <= alloc_node;
                  tail <= alloc_node;
                end else if (ins_pos == '0) begin
                  head <= alloc_node;
                end else if (ins_pos == cntx) begin
                  tail <= alloc_node;
                end else begin
                  steps <= IDX_W'(ins_pos - XW'(1));
                end
              end
            end
            ACT_REM_FIRST, ACT_REM_LAST, ACT_REM_AT: begin
              if (rem_pos < cntx) begin
                ok        <= 1'b1;
                cnt       <= cnt - CNT_W'(1);
                nd        <= head;
                from_link <= 1'b0;
                has_pred  <= (rem_pos != '0);
                steps     <= IDX_W'(rem_pos - XW'(1));
              end
            end
            ACT_READ: begin
              if (posx < cntx) begin
                ok    <= 1'b1;
                steps <= IDX_W'(posx);
              end
            end
            ACT_CLEAR: begin
              ok    <= 1'b1;
              head  <= '0;
              tail  <= '0;
              cnt   <= '0;
              fresh <= '0;
              ftop  <= '0;
              fnum  <= '0;
            end
          endcase
        end
        ST_WALK: begin
          cur <= node_now;
          if (steps != '0) begin
            steps <= steps - IDX_W'(1);
            pend  <= 1'b1;
          end
        end
        ST_LINK: begin
          from_link <= 1'b1;
        end
        ST_NODE: begin
          nd <= nd_now;
        end
        ST_FIX: begin
          result <= val_rdata;
          if (!has_pred) begin
            head <= link_rdata;
          end else if (nd == tail) begin
            tail <= cur;
          end
        end
        ST_FREE: begin
          ftop <= nd;
          fnum <= fnum + CNT_W'(1);
        end
        ST_VGET: begin
          result <= val_rdata;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/positional_linked_list_manager.sv
// positional linked list manager: append, prepend, insert, remove, read and clear
// append, prepend, clear and failed requests go from setup straight to the result, with no walk
// positional requests walk one link per cycle to their position before the result
// one request at a time: the next one is taken once the result has left the sequencer
// the result sits in an output register, so a new request is taken while it waits
// reset: synchronous, empties the list and the free list; no memory clearing pass
`default_nettype none
module positional_linked_list_manager #(
  parameter int CAPACITY  = plll_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = plll_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // action [2:0], position [7:3], item_word [39:8]
  input  logic [plll_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // success [0], result_word [32:1], entry_count [37:33], is_empty [38], zero [39]
  output logic [plll_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import plll_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 out_free, res_valid;
  status_t              res_status;
  logic [WORD_BITS-1:0] res_word;
  logic [CNT_W-1:0]     res_count;
  logic [IDX_W-1:0]     link_raddr, link_rdata, link_waddr, link_wdata;
  logic                 link_we, val_we;
  logic [IDX_W-1:0]     val_raddr, val_waddr;
  logic [WORD_BITS-1:0] val_rdata, val_wdata;
  logic                 out_valid;
  logic [M_TDATA_W-1:0] out_data;

  assign out_free = !out_valid || m_axis_tready;

  plll_seq #(.CAPACITY(CAPACITY), .WORD_BITS(WORD_BITS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_action   (action_t'(s_axis_tdata[2:0])),
    .in_position (s_axis_tdata[7:3]),
    .in_word     (WORD_BITS'(s_axis_tdata[39:8])),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res_status  (res_status),
    .res_word    (res_word),
    .res_count   (res_count),
    .link_raddr  (link_raddr),
    .link_rdata  (link_rdata),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .val_raddr   (val_raddr),
    .val_rdata   (val_rdata),
    .val_we      (val_we),
    .val_waddr   (val_waddr),
    .val_wdata   (val_wdata)
  );

  plll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .raddr (link_raddr),
    .rdata (link_rdata),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata)
  );

  plll_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .raddr (val_raddr),
    .rdata (val_rdata),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= {1'b0, res_status.is_empty, IO_COUNT_W'(res_count),
                   IO_WORD_W'(res_word), res_status.success};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
`default_nettype wire

// File: rtl/core/plll_checker.sv
// port checker for the positional linked list manager, bound to the top level
`default_nettype none
module plll_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [plll_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [plll_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import plll_pkg::*;

  logic [IO_WORD_W-1:0]  chk_word;
  logic [IO_COUNT_W-1:0] chk_count;

  assign chk_word  = m_axis_tdata[32:1];
  assign chk_count = m_axis_tdata[37:33];

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_fail_zero_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> chk_word == '0)
    else $error("failed request returned a nonzero word");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[38] |-> chk_count == '0)
    else $error("empty flag with nonzero count");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[39])
    else $error("padding bit set");

endmodule

bind positional_linked_list_manager plll_checker u_plll_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: test/tb.sv
// testbench for the positional linked list manager: directed table, then random requests
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import plll_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int NODE_W       = $clog2(CAP);
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = CAP + 20;

  typedef struct packed {
    logic                  success;
    logic [IO_WORD_W-1:0]  word;
    logic [IO_COUNT_W-1:0] count;
    logic                  empty;
  } list_reply_t;

  typedef struct {
    action_t              act;
    logic [POS_W-1:0]     pos;
    logic [IO_WORD_W-1:0] word;
    int                   reps;
    bit                   typed;
    list_reply_t          want;
  } request_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // own copy of the list and the free list
  logic [IO_WORD_W-1:0]  node_value [CAP];
  logic [NODE_W-1:0]     node_link [CAP];
  logic [NODE_W-1:0]     head_node, tail_node, free_head;
  logic [IO_COUNT_W-1:0] list_count, free_left;

  list_reply_t  pending_replies[$];
  request_row_t directed_rows[$];
  int           errors = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           calm = 1'b0;

  positional_linked_list_manager u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic void rechain_free_list();
    for (int i = 0; i < CAP; i++) begin
      node_link[i] = NODE_W'((i + 1) % CAP);
    end
    free_head  = '0;
    free_left  = IO_COUNT_W'(CAP);
    head_node  = '0;
    tail_node  = '0;
    list_count = '0;
  endfunction

  function automatic logic [NODE_W-1:0] node_after(int steps);
    logic [NODE_W-1:0] n;
    n = head_node;
    for (int i = 0; i < steps; i++) begin
      n = node_link[n];
    end
    return n;
  endfunction

  function automatic bit link_in(int pos, logic [IO_WORD_W-1:0] word);
    logic [NODE_W-1:0] n, pred;
    if (free_left == 0 || pos > list_count) return 1'b0;
    n = free_head;
    free_head = node_link[n];
    free_left--;
    node_value[n] = word;
    if (list_count == 0) begin
      head_node = n;
      tail_node = n;
    end else if (pos == 0) begin
      node_link[n] = head_node;
      head_node = n;
    end else begin
      pred = node_after(pos - 1);
      node_link[n] = node_link[pred];
      node_link[pred] = n;
      if (pred == tail_node) tail_node = n;
    end
    list_count++;
    return 1'b1;
  endfunction

  function automatic bit unlink_at(int pos, output logic [IO_WORD_W-1:0] word);
    logic [NODE_W-1:0] n, pred;
    word = '0;
    if (pos >= list_count) return 1'b0;
    if (pos == 0) begin
      n = head_node;
      head_node = node_link[n];
    end else begin
      pred = node_after(pos - 1);
      n = node_link[pred];
      node_link[pred] = node_link[n];
      if (n == tail_node) tail_node = pred;
    end
    word = node_value[n];
    node_link[n] = free_head;
    free_head = n;
    free_left++;
    list_count--;
    if (list_count == 0) begin
      head_node = '0;
      tail_node = '0;
    end
    return 1'b1;
  endfunction

  // updates the list copy and returns the reply the block should give
  function automatic list_reply_t list_apply(action_t act, int pos,
                                             logic [IO_WORD_W-1:0] word);
    list_reply_t r;
    logic [IO_WORD_W-1:0] data;
    bit ok;
    data = '0;
    ok = 1'b0;
    case (act)
      ACT_APPEND:    ok = link_in(list_count, word);
      ACT_PREPEND:   ok = link_in(0, word);
      ACT_INSERT:    ok = link_in(pos, word);
      ACT_REM_FIRST: ok = unlink_at(0, data);
      ACT_REM_LAST:  ok = (list_count != 0) ? unlink_at(list_count - 1, data) : 1'b0;
      ACT_REM_AT:    ok = unlink_at(pos, data);
      ACT_READ: begin
        if (pos < list_count) begin
          data = node_value[node_after(pos)];
          ok = 1'b1;
        end
      end
      default: begin
        rechain_free_list();
        ok = 1'b1;
      end
    endcase
    r.success = ok;
    r.word    = ok ? data : '0;
    r.count   = list_count;
    r.empty   = (list_count == 0);
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IO_WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(action_t act, int pos, logic [IO_WORD_W-1:0] word, int reps,
                         bit typed, list_reply_t want);
    request_row_t row;
    row.act   = act;
    row.pos   = POS_W'(pos);
    row.word  = word;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_request(action_t act, logic [POS_W-1:0] pos,
                              logic [IO_WORD_W-1:0] word, bit typed, list_reply_t want);
    int gap;
    list_reply_t got;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {word, pos, act};
    do @(posedge clk); while (!s_axis_tready);
    got = list_apply(act, pos, word);
    pending_replies.push_back(typed ? want : got);
  endtask

  // receiver side: random stalls and the reply check
  always @(posedge clk) begin
    list_reply_t exp_reply;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:3]:   begin
          m_axis_tready <= 1'b0;
          stall_left <= $urandom_range(10, 60);
        end
        [4:28]:  m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request waiting: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_reply = pending_replies.pop_front();
        if (m_axis_tdata[0] !== exp_reply.success) begin
          $error("success: expected %0d, got %0d", exp_reply.success, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[32:1] !== exp_reply.word) begin
          $error("result_word: expected %h, got %h", exp_reply.word, m_axis_tdata[32:1]);
          errors++;
        end
        if (m_axis_tdata[37:33] !== exp_reply.count) begin
          $error("entry_count: expected %0d, got %0d", exp_reply.count, m_axis_tdata[37:33]);
          errors++;
        end
        if (m_axis_tdata[38] !== exp_reply.empty) begin
          $error("is_empty: expected %0d, got %0d", exp_reply.empty, m_axis_tdata[38]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    request_row_t row;
    action_t act;
    logic [POS_W-1:0] pos;
    bit growing;
    bit want_insert;
    int r;

    rechain_free_list();
    growing = 1'b1;

    // empty list failures, clear, small list, then fill to full and back
    add_row(ACT_READ,      0, '0,           1, 1, {1'b0, 32'h0, 5'd0, 1'b1});
    add_row(ACT_REM_FIRST, 0, '0,           1, 1, {1'b0, 32'h0, 5'd0, 1'b1});
    add_row(ACT_REM_LAST,  0, '0,           1, 1, {1'b0, 32'h0, 5'd0, 1'b1});
    add_row(ACT_REM_AT,    0, '0,           1, 1, {1'b0, 32'h0, 5'd0, 1'b1});
    add_row(ACT_INSERT,    1, 32'h1,        1, 1, {1'b0, 32'h0, 5'd0, 1'b1});
    add_row(ACT_CLEAR,     0, '0,           1, 1, {1'b1, 32'h0, 5'd0, 1'b1});
    add_row(ACT_APPEND,    0, 32'hffffffff, 1, 1, {1'b1, 32'h0, 5'd1, 1'b0});
    add_row(ACT_PREPEND,   0, 32'h0,        1, 1, {1'b1, 32'h0, 5'd2, 1'b0});
    add_row(ACT_INSERT,    1, 32'ha5a5a5a5, 1, 1, {1'b1, 32'h0, 5'd3, 1'b0});
    // insert at the end acts as append
    add_row(ACT_INSERT,    3, 32'h5a5a5a5a, 1, 1, {1'b1, 32'h0, 5'd4, 1'b0});
    add_row(ACT_READ,      3, 32'hffffffff, 1, 1, {1'b1, 32'h5a5a5a5a, 5'd4, 1'b0});
    add_row(ACT_READ,      4, '0,           1, 1, {1'b0, 32'h0, 5'd4, 1'b0});
    add_row(ACT_REM_AT,    1, '0,           1, 1, {1'b1, 32'ha5a5a5a5, 5'd3, 1'b0});
    add_row(ACT_REM_LAST,  0, '0,           1, 1, {1'b1, 32'h5a5a5a5a, 5'd2, 1'b0});
    add_row(ACT_REM_FIRST, 0, '0,           1, 1, {1'b1, 32'h0, 5'd1, 1'b0});
    add_row(ACT_INSERT,    0, 32'h12345678, 1, 0, '0);
    // fills the store, last one fails on full
    add_row(ACT_APPEND,    0, 32'h00000001, 15, 0, '0);
    add_row(ACT_PREPEND,   0, 32'hdeadbeef, 1, 1, {1'b0, 32'h0, 5'd16, 1'b0});
    add_row(ACT_INSERT,   16, 32'hdeadbeef, 1, 1, {1'b0, 32'h0, 5'd16, 1'b0});
    add_row(ACT_READ,     15, '0,           1, 0, '0);
    add_row(ACT_READ,     16, '0,           1, 1, {1'b0, 32'h0, 5'd16, 1'b0});
    add_row(ACT_REM_AT,   15, '0,           1, 0, '0);
    add_row(ACT_REM_AT,    7, '0,           1, 0, '0);
    add_row(ACT_INSERT,   14, 32'h80000000, 1, 0, '0);
    add_row(ACT_CLEAR,     0, '0,           1, 1, {1'b1, 32'h0, 5'd0, 1'b1});
    add_row(ACT_REM_LAST,  0, '0,           1, 1, {1'b0, 32'h0, 5'd0, 1'b1});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        send_request(row.act, row.pos, row.word + IO_WORD_W'(k), row.typed, row.want);
      end
    end

    // grows to full and shrinks to empty in turns, lingering a little at each end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 500 && n < 600);
      if (growing && list_count == CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && list_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      want_insert = growing ? (r < 75) : (r < 30);
      if ($urandom_range(0, 99) < 6) begin
        act = action_t'($urandom_range(0, 7));
        pos = POS_W'($urandom_range(0, 16));
      end else if (want_insert) begin
        case ($urandom_range(0, 2))
          0:       act = ACT_APPEND;
          1:       act = ACT_PREPEND;
          default: act = ACT_INSERT;
        endcase
        pos = POS_W'($urandom_range(0, list_count));
      end else begin
        case ($urandom_range(0, 3))
          0:       act = ACT_REM_FIRST;
          1:       act = ACT_REM_LAST;
          2:       act = ACT_REM_AT;
          default: act = ACT_READ;
        endcase
        pos = (list_count != 0) ? POS_W'($urandom_range(0, list_count - 1)) : '0;
      end
      send_request(act, pos, pick_word(), 1'b0, '0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
